// ===== rtl/touch_panel_sample_filter_defines.svh =====
// Assertion macros for the touch panel sample filter.
// Used by the RTL files that carry assertions; expects clk and rst in scope.
`ifndef TOUCH_PANEL_SAMPLE_FILTER_DEFINES_SVH
`define TOUCH_PANEL_SAMPLE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define TPSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define TPSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TPSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPSF_ASSERT(lbl, prop, msg)
`define TPSF_ASSERT_IMP(lbl, ante, cons, msg)
`define TPSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tpsf_pkg.sv =====
// Shared types and constants for the touch panel sample filter.
// No dependencies; imported by every RTL module of the block.
package tpsf_pkg;

  // Field widths
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned VAL_SHIFT = 3;
  localparam int unsigned VAL_W     = RAW_W - VAL_SHIFT;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned OFS_W     = 16;
  localparam int unsigned LIMIT_W   = 13;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 17;

  // Burst shape
  localparam int unsigned MAX_WORDS             = 6;
  localparam int unsigned SAMPLES_PER_BURST_DEF = 6;
  localparam int unsigned VAL_MAX               = (1 << VAL_W) - 1;

  // Reciprocal divide: q = (n * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 18;

  // Gain is fixed point with this many fraction bits
  localparam int unsigned GAIN_FRAC = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);
  localparam logic [COORD_W-1:0] COORD_IDLE  = 16'hFFFF;
  localparam logic [COORD_W-1:0] COORD_MAX   = 16'hFFFF;

  // Input command codes
  localparam logic CMD_PEN_UP = 1'b0;
  localparam logic CMD_BURST  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_MODE    = 3'd0,
    REG_X_GAIN      = 3'd1,
    REG_X_OFFSET    = 3'd2,
    REG_Y_GAIN      = 3'd3,
    REG_Y_OFFSET    = 3'd4,
    REG_AGREE_LIMIT = 3'd5
  } cfg_reg_t;

  // Position inside a pen-down scan
  typedef enum logic [1:0] {
    BURST_X1 = 2'd0,
    BURST_Y1 = 2'd1,
    BURST_X2 = 2'd2,
    BURST_Y2 = 2'd3
  } burst_t;

  // Rank flags a lane reports to the merge stage
  typedef struct packed {
    logic is_max;
    logic is_min;
  } lane_flags_t;

endpackage

// ===== rtl/tpsf_lane.sv =====
// One ranking lane: compares its sample against all others of the burst.
// Depends on tpsf_pkg. Ties go to the lowest lane index.
module tpsf_lane import tpsf_pkg::*; #(
  parameter int unsigned Lanes = MAX_WORDS,
  parameter int unsigned Index = 0
) (
  input  logic [VAL_W-1:0] vals [Lanes],
  output lane_flags_t      flags
);

  logic [VAL_W-1:0] own;

  assign own = vals[Index];

  // Largest: beats lower lanes strictly, higher lanes or equal.
  // Smallest: the mirror image.
  always_comb begin
    flags.is_max = 1'b1;
    flags.is_min = 1'b1;
    for (int j = 0; j < int'(Lanes); j++) begin
      if (j < int'(Index)) begin
        if (!(own > vals[j])) flags.is_max = 1'b0;
        if (!(own < vals[j])) flags.is_min = 1'b0;
      end else if (j > int'(Index)) begin
        if (!(own >= vals[j])) flags.is_max = 1'b0;
        if (!(own <= vals[j])) flags.is_min = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tpsf_merge.sv =====
// Merge of the lanes: total, extremes, then trimmed mean by reciprocal multiply.
// Depends on tpsf_pkg; two register stages driven by load enables from the top.
module tpsf_merge import tpsf_pkg::*; #(
  parameter int unsigned Lanes = MAX_WORDS
) (
  input  logic               clk,
  input  logic               a_load,
  input  logic               b_load,
  input  logic [VAL_W-1:0]   vals [Lanes],
  input  lane_flags_t        flags [Lanes],
  output logic [VAL_W-1:0]   reading
);

  localparam int unsigned Divisor = Lanes - 2;
  localparam int unsigned SumW    = $clog2(Lanes * VAL_MAX + 1);
  localparam int unsigned KeptW   = $clog2(Divisor * VAL_MAX + 1);
  localparam int unsigned Recip   = ((1 << RECIP_SHIFT) + Divisor - 1) / Divisor;
  localparam int unsigned RecipW  = $clog2(Recip + 1);
  localparam int unsigned ProdW   = KeptW + RecipW;

  logic [SumW-1:0]   sum_all;
  logic [VAL_W-1:0]  hi_sel;
  logic [VAL_W-1:0]  lo_sel;
  logic [SumW-1:0]   sum;
  logic [VAL_W-1:0]  hi;
  logic [VAL_W-1:0]  lo;
  logic [SumW-1:0]   kept_full;
  logic [KeptW-1:0]  kept;
  logic [ProdW-1:0]  prod;

  // Combine lanes: one-hot picks of the extremes and the full sum
  always_comb begin
    sum_all = '0;
    hi_sel  = '0;
    lo_sel  = '0;
    for (int i = 0; i < int'(Lanes); i++) begin
      sum_all = sum_all + SumW'(vals[i]);
      hi_sel  = hi_sel | (vals[i] & {VAL_W{flags[i].is_max}});
      lo_sel  = lo_sel | (vals[i] & {VAL_W{flags[i].is_min}});
    end
  end

  // Stage A registers
  always_ff @(posedge clk) begin
    if (a_load) begin
      sum <= sum_all;
      hi  <= hi_sel;
      lo  <= lo_sel;
    end
  end

  // Drop the extremes and divide by the kept count
  assign kept_full = sum - SumW'(hi) - SumW'(lo);
  assign kept      = kept_full[KeptW-1:0];
  assign prod      = ProdW'(kept) * ProdW'(Recip);

  // Stage B register
  always_ff @(posedge clk) begin
    if (b_load) begin
      reading <= prod[RECIP_SHIFT +: VAL_W];
    end
  end

endmodule

// ===== rtl/tpsf_scale.sv =====
// Gain and offset for one axis: registered product, then offset and clamp.
// Depends on tpsf_pkg. Product is floored by an arithmetic shift.
module tpsf_scale import tpsf_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [GAIN_W-1:0] gain,
  input  logic signed [OFS_W-1:0]  offset,
  input  logic [VAL_W-1:0]         avg,
  output logic [COORD_W-1:0]       scaled
);

  localparam int unsigned ProdW = GAIN_W + VAL_W + 1;
  localparam int unsigned ShW   = ProdW - GAIN_FRAC;
  localparam int unsigned AccW  = ShW + 1;

  logic signed [ProdW-1:0] prod;
  logic signed [ShW-1:0]   shifted;
  logic signed [AccW-1:0]  acc;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= ProdW'(gain) * $signed({1'b0, avg});
    end
  end

  // Floor by 2^GAIN_FRAC, add offset, clamp to the coordinate range
  assign shifted = prod[ProdW-1:GAIN_FRAC];
  assign acc     = AccW'(shifted) + AccW'(offset);

  always_comb begin
    if (acc < 0) begin
      scaled = '0;
    end else if (acc > $signed(AccW'(COORD_MAX))) begin
      scaled = COORD_MAX;
    end else begin
      scaled = acc[COORD_W-1:0];
    end
  end

endmodule

// ===== rtl/touch_panel_sample_filter.sv =====
// Touch panel sample filter, top level: lanes, merge, scan control, scaling.
// Five register stages (A to E) with bubble fill carry each transaction.
// Throughput: one transaction per cycle while result_stall lets E drain.
// Reset (rst, synchronous): empties the pipeline, clears scan state and held
// coordinates, and sets the config registers to their defaults.
`include "touch_panel_sample_filter_defines.svh"
module touch_panel_sample_filter import tpsf_pkg::*; #(
  parameter int unsigned SAMPLES_PER_BURST = SAMPLES_PER_BURST_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic                 cmd,
  input  logic [RAW_W-1:0]     word0,
  input  logic [RAW_W-1:0]     word1,
  input  logic [RAW_W-1:0]     word2,
  input  logic [RAW_W-1:0]     word3,
  input  logic [RAW_W-1:0]     word4,
  input  logic [RAW_W-1:0]     word5,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 pen_pressed,
  output logic                 new_press,
  output logic                 reading_ok,
  output logic [COORD_W-1:0]   x_coord,
  output logic [COORD_W-1:0]   y_coord,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned Lanes = (SAMPLES_PER_BURST < MAX_WORDS) ?
                                  SAMPLES_PER_BURST : MAX_WORDS;

  // Config registers
  logic                     raw_mode;
  logic signed [GAIN_W-1:0] x_gain;
  logic signed [OFS_W-1:0]  x_offset;
  logic signed [GAIN_W-1:0] y_gain;
  logic signed [OFS_W-1:0]  y_offset;
  logic [LIMIT_W-1:0]       agree_limit;

  // Pipeline control
  logic a_valid, b_valid, c_valid, d_valid;
  logic a_ready, b_ready, c_ready, d_ready, e_ready;
  logic a_cmd, b_cmd, c_cmd, d_cmd;
  logic c_take, e_take;

  // Lane data
  logic [RAW_W-1:0]  words [MAX_WORDS];
  logic [VAL_W-1:0]  vals  [Lanes];
  lane_flags_t       flags [Lanes];
  logic [VAL_W-1:0]  reading;

  // Scan state
  burst_t            burst_index, burst_next;
  logic [VAL_W-1:0]  first_x, first_y, second_x;
  logic              c_ok, d_ok;
  logic [VAL_W-1:0]  c_ax, c_ay, d_ax, d_ay;
  logic [VAL_W-1:0]  diff_x, diff_y;
  logic [VAL_W:0]    sum_x, sum_y;
  logic              ok_now;

  // Output state
  logic              pressed_flag;
  logic [COORD_W-1:0] held_x, held_y;
  logic [COORD_W-1:0] scaled_x, scaled_y;

  // Configuration writes; indexes past the list are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode    <= 1'b0;
      x_gain      <= '0;
      x_offset    <= '0;
      y_gain      <= '0;
      y_offset    <= '0;
      agree_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RAW_MODE:    raw_mode    <= cfg_data[0];
        REG_X_GAIN:      x_gain      <= cfg_data[GAIN_W-1:0];
        REG_X_OFFSET:    x_offset    <= cfg_data[OFS_W-1:0];
        REG_Y_GAIN:      y_gain      <= cfg_data[GAIN_W-1:0];
        REG_Y_OFFSET:    y_offset    <= cfg_data[OFS_W-1:0];
        REG_AGREE_LIMIT: agree_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage takes a new transaction when empty or draining
  assign e_ready      = !result_valid || !result_stall;
  assign d_ready      = !d_valid || e_ready;
  assign c_ready      = !c_valid || d_ready;
  assign b_ready      = !b_valid || c_ready;
  assign a_ready      = !a_valid || b_ready;
  assign sample_stall = !a_ready;
  assign c_take       = c_ready && b_valid;
  assign e_take       = e_ready && d_valid;

  // Lanes: one per used word, each ranks its sample
  assign words[0] = word0;
  assign words[1] = word1;
  assign words[2] = word2;
  assign words[3] = word3;
  assign words[4] = word4;
  assign words[5] = word5;

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    assign vals[i] = words[i][RAW_W-1 -: VAL_W];
    tpsf_lane #(
      .Lanes (Lanes),
      .Index (i)
    ) u_lane (
      .vals  (vals),
      .flags (flags[i])
    );
  end

  tpsf_merge #(
    .Lanes (Lanes)
  ) u_merge (
    .clk     (clk),
    .a_load  (a_ready),
    .b_load  (b_ready),
    .vals    (vals),
    .flags   (flags),
    .reading (reading)
  );

  // Stage A/B valid and command tags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= sample_valid;
      if (b_ready) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) a_cmd <= cmd;
    if (b_ready) b_cmd <= a_cmd;
  end

  // Stage C: agreement check and pair averages for the closing burst
  assign diff_x = (first_x > second_x) ? first_x - second_x : second_x - first_x;
  assign diff_y = (first_y > reading) ? first_y - reading : reading - first_y;
  assign ok_now = (LIMIT_W'(diff_x) < agree_limit) && (LIMIT_W'(diff_y) < agree_limit);
  assign sum_x  = {1'b0, first_x} + {1'b0, second_x};
  assign sum_y  = {1'b0, first_y} + {1'b0, reading};

  // Scan position
  always_comb begin
    burst_next = burst_index;
    if (c_take) begin
      if (b_cmd == CMD_PEN_UP) begin
        burst_next = BURST_X1;
      end else begin
        unique case (burst_index)
          BURST_X1: burst_next = BURST_Y1;
          BURST_Y1: burst_next = BURST_X2;
          BURST_X2: burst_next = BURST_Y2;
          BURST_Y2: burst_next = BURST_X1;
          default:  burst_next = BURST_X1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_index <= BURST_X1;
    end else begin
      burst_index <= burst_next;
    end
  end

  // Stage C registers; partial bursts end here with no result
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid  <= 1'b0;
      first_x  <= '0;
      first_y  <= '0;
      second_x <= '0;
    end else if (c_ready) begin
      c_valid <= b_valid && ((b_cmd == CMD_PEN_UP) || (burst_index == BURST_Y2));
      if (b_valid && (b_cmd == CMD_BURST)) begin
        unique case (burst_index)
          BURST_X1: first_x  <= reading;
          BURST_Y1: first_y  <= reading;
          BURST_X2: second_x <= reading;
          BURST_Y2: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_cmd <= b_cmd;
      c_ok  <= ok_now;
      c_ax  <= sum_x[VAL_W:1];
      c_ay  <= sum_y[VAL_W:1];
    end
  end

  // Stage D: gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_cmd <= c_cmd;
      d_ok  <= c_ok;
      d_ax  <= c_ax;
      d_ay  <= c_ay;
    end
  end

  tpsf_scale u_scale_x (
    .clk    (clk),
    .load   (d_ready),
    .gain   (x_gain),
    .offset (x_offset),
    .avg    (c_ax),
    .scaled (scaled_x)
  );

  tpsf_scale u_scale_y (
    .clk    (clk),
    .load   (d_ready),
    .gain   (y_gain),
    .offset (y_offset),
    .avg    (c_ay),
    .scaled (scaled_y)
  );

  // Stage E: press tracking, held coordinates and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pressed_flag <= 1'b0;
      held_x       <= '0;
      held_y       <= '0;
      pen_pressed  <= 1'b0;
      new_press    <= 1'b0;
      reading_ok   <= 1'b0;
    end else if (e_ready) begin
      result_valid <= d_valid;
      if (d_valid) begin
        if (d_cmd == CMD_PEN_UP) begin
          // first release clears the press, a second one parks the coordinates
          if (pressed_flag) begin
            pressed_flag <= 1'b0;
          end else begin
            held_x <= COORD_IDLE;
            held_y <= COORD_IDLE;
          end
          pen_pressed <= 1'b0;
          new_press   <= 1'b0;
          reading_ok  <= 1'b0;
        end else begin
          if (d_ok) begin
            held_x <= raw_mode ? COORD_W'(d_ax) : scaled_x;
            held_y <= raw_mode ? COORD_W'(d_ay) : scaled_y;
          end
          pressed_flag <= 1'b1;
          pen_pressed  <= 1'b1;
          new_press    <= !pressed_flag;
          reading_ok   <= d_ok;
        end
      end
    end
  end

  assign x_coord = held_x;
  assign y_coord = held_y;

  // Checks
  `TPSF_ASSERT_NXT(a_sample_lands, sample_valid && !sample_stall, a_valid, "accepted sample lost")
  `TPSF_ASSERT_NXT(a_penup_clears, e_take && (d_cmd == CMD_PEN_UP), !pressed_flag, "pen-up left press set")
  `TPSF_ASSERT_NXT(a_penup_rescan, c_take && (b_cmd == CMD_PEN_UP), burst_index == BURST_X1, "pen-up did not restart scan")
  `TPSF_ASSERT_IMP(a_press_flag, result_valid && new_press, pressed_flag && pen_pressed, "new press without press state")
  `TPSF_ASSERT_IMP(a_ok_pressed, result_valid && reading_ok, pen_pressed, "good reading on pen-up")

endmodule

// ===== tb/sv/touch_panel_sample_filter_tb.sv =====
// Self-checking testbench for touch_panel_sample_filter: directed table, then random scans.
// Depends on tpsf_pkg and the touch_panel_sample_filter RTL; predicts results in-line.
`timescale 1ns / 100ps
module touch_panel_sample_filter_tb;
  import tpsf_pkg::*;

  localparam int WORDS_USED = (SAMPLES_PER_BURST_DEF < MAX_WORDS) ?
                              SAMPLES_PER_BURST_DEF : MAX_WORDS;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 20;

  typedef struct packed {
    logic                           cmd;
    logic [MAX_WORDS-1:0][RAW_W-1:0] words;
  } sample_t;

  typedef struct packed {
    logic               pen_pressed;
    logic               new_press;
    logic               reading_ok;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } result_t;

  typedef struct {
    sample_t s;
    bit      typed;
    result_t res;
  } directed_row_t;

  typedef struct {
    bit                        raw;
    logic signed [GAIN_W-1:0]  gx;
    logic signed [OFS_W-1:0]   ox;
    logic signed [GAIN_W-1:0]  gy;
    logic signed [OFS_W-1:0]   oy;
    logic [LIMIT_W-1:0]        lim;
  } cal_cfg_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  logic                 cmd = CMD_PEN_UP;
  logic [RAW_W-1:0]     word0 = '0, word1 = '0, word2 = '0;
  logic [RAW_W-1:0]     word3 = '0, word4 = '0, word5 = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 pen_pressed, new_press, reading_ok;
  logic [COORD_W-1:0]   x_coord, y_coord;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  touch_panel_sample_filter dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .cmd(cmd),
    .word0(word0), .word1(word1), .word2(word2),
    .word3(word3), .word4(word4), .word5(word5),
    .result_valid(result_valid), .result_stall(result_stall),
    .pen_pressed(pen_pressed), .new_press(new_press), .reading_ok(reading_ok),
    .x_coord(x_coord), .y_coord(y_coord),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow calibration registers
  bit                       raw_sel = 1'b0;
  logic signed [GAIN_W-1:0] gain_x = '0, gain_y = '0;
  logic signed [OFS_W-1:0]  ofs_x = '0, ofs_y = '0;
  logic [LIMIT_W-1:0]       agree_lim = LIMIT_RESET;

  // Shadow scan state
  bit                 pen_down = 1'b0;
  burst_t             scan_pos = BURST_X1;
  logic [VAL_W-1:0]   first_x = '0, first_y = '0, second_x = '0;
  logic [COORD_W-1:0] held_x = '0, held_y = '0;

  result_t       coord_reports_due[$];
  directed_row_t touch_rows[$];
  int            mismatch_count = 0;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;
  int            send_quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("touch_panel_sample_filter_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------
  function automatic bit close_enough(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d < agree_lim;
  endfunction

  // gain has 14 fraction bits; floor divide then offset, clamp to 16 bits
  function automatic logic [COORD_W-1:0] apply_cal(logic [VAL_W-1:0] avg,
                                                   logic signed [GAIN_W-1:0] gain,
                                                   logic signed [OFS_W-1:0] ofs);
    longint prod, q;
    prod = longint'(gain) * longint'({1'b0, avg});
    q = (prod >>> GAIN_FRAC) + longint'(ofs);
    if (q < 0) return '0;
    if (q > 65535) return COORD_MAX;
    return q[COORD_W-1:0];
  endfunction

  function automatic bit filter_sample(input sample_t s, output result_t r);
    logic [VAL_W-1:0] v, hi, lo, reading, ax, ay;
    logic [RAW_W-1:0] sum;
    bit               agreed;
    r = '0;
    if (s.cmd == CMD_PEN_UP) begin
      // partial scans are dropped; second release idles the coordinates
      scan_pos = BURST_X1;
      if (pen_down) begin
        pen_down = 1'b0;
      end else begin
        held_x = COORD_IDLE;
        held_y = COORD_IDLE;
      end
      r.x_coord = held_x;
      r.y_coord = held_y;
      return 1'b1;
    end
    // trimmed mean: drop largest and smallest
    hi  = VAL_W'(s.words[0] >> VAL_SHIFT);
    lo  = hi;
    sum = '0;
    for (int k = 0; k < WORDS_USED; k++) begin
      v = VAL_W'(s.words[k] >> VAL_SHIFT);
      if (v > hi) hi = v;
      if (v < lo) lo = v;
      sum = sum + RAW_W'(v);
    end
    sum = sum - RAW_W'(hi) - RAW_W'(lo);
    reading = VAL_W'(sum / (WORDS_USED - 2));
    case (scan_pos)
      BURST_X1: begin first_x  = reading; scan_pos = BURST_Y1; return 1'b0; end
      BURST_Y1: begin first_y  = reading; scan_pos = BURST_X2; return 1'b0; end
      BURST_X2: begin second_x = reading; scan_pos = BURST_Y2; return 1'b0; end
      default: scan_pos = BURST_X1;
    endcase
    agreed = close_enough(first_x, second_x) && close_enough(first_y, reading);
    if (agreed) begin
      ax = VAL_W'(({1'b0, first_x} + {1'b0, second_x}) >> 1);
      ay = VAL_W'(({1'b0, first_y} + {1'b0, reading}) >> 1);
      if (raw_sel) begin
        held_x = COORD_W'(ax);
        held_y = COORD_W'(ay);
      end else begin
        held_x = apply_cal(ax, gain_x, ofs_x);
        held_y = apply_cal(ay, gain_y, ofs_y);
      end
    end
    r.pen_pressed = 1'b1;
    r.new_press   = !pen_down;
    r.reading_ok  = agreed;
    r.x_coord     = held_x;
    r.y_coord     = held_y;
    pen_down = 1'b1;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (coord_reports_due.size() == 0) begin
        $error("unexpected result transaction x=%0h y=%0h", x_coord, y_coord);
        mismatch_count++;
      end else begin
        exp_r = coord_reports_due.pop_front();
        if (pen_pressed !== exp_r.pen_pressed) begin
          $error("pen_pressed expected %0d got %0d", exp_r.pen_pressed, pen_pressed);
          mismatch_count++;
        end
        if (new_press !== exp_r.new_press) begin
          $error("new_press expected %0d got %0d", exp_r.new_press, new_press);
          mismatch_count++;
        end
        if (reading_ok !== exp_r.reading_ok) begin
          $error("reading_ok expected %0d got %0d", exp_r.reading_ok, reading_ok);
          mismatch_count++;
        end
        if (x_coord !== exp_r.x_coord) begin
          $error("x_coord expected %0h got %0h", exp_r.x_coord, x_coord);
          mismatch_count++;
        end
        if (y_coord !== exp_r.y_coord) begin
          $error("y_coord expected %0h got %0h", exp_r.y_coord, y_coord);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Result-side stall: random bursts, quiet stretches, one long hold
  // ---------------------------------------------------------------
  initial begin
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on) begin
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          case ($urandom_range(0, 15))
            0, 1, 2: stall_left = $urandom_range(1, 19);
            3:       quiet_left = $urandom_range(20, 200);
            default: ;
          endcase
        end
      end
      result_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------
  // Sample channel driver
  // ---------------------------------------------------------------
  task automatic send_sample(input sample_t s, input bit typed = 1'b0,
                             input result_t typed_res = '0);
    result_t r;
    int      gap;
    @(negedge clk);
    sample_valid <= 1'b1;
    cmd   <= s.cmd;
    word0 <= s.words[0];
    word1 <= s.words[1];
    word2 <= s.words[2];
    word3 <= s.words[3];
    word4 <= s.words[4];
    word5 <= s.words[5];
    do @(posedge clk); while (sample_stall);
    if (filter_sample(s, r)) coord_reports_due.push_back(typed ? typed_res : r);
    gap = 0;
    if (idle_on) begin
      if (send_quiet > 0) begin
        send_quiet--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2: gap = $urandom_range(1, 19);
          3:       send_quiet = $urandom_range(20, 150);
          default: ;
        endcase
      end
    end
    if (gap > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic release_samples();
    @(negedge clk);
    sample_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (coord_reports_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RAW_MODE:    raw_sel   = d[0];
      REG_X_GAIN:      gain_x    = d;
      REG_X_OFFSET:    ofs_x     = d[OFS_W-1:0];
      REG_Y_GAIN:      gain_y    = d;
      REG_Y_OFFSET:    ofs_y     = d[OFS_W-1:0];
      REG_AGREE_LIMIT: agree_lim = d[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // only while idle: drain results and let trailing bursts clear the pipe
  task automatic load_cal(input cal_cfg_t c);
    release_samples();
    wait_drained();
    repeat (10) @(posedge clk);
    write_reg(REG_RAW_MODE,    CFG_DAT_W'(c.raw));
    write_reg(REG_X_GAIN,      c.gx);
    write_reg(REG_X_OFFSET,    {c.ox[OFS_W-1], c.ox});
    write_reg(REG_Y_GAIN,      c.gy);
    write_reg(REG_Y_OFFSET,    {c.oy[OFS_W-1], c.oy});
    write_reg(REG_AGREE_LIMIT, CFG_DAT_W'(c.lim));
  endtask

  function automatic cal_cfg_t rand_cal();
    cal_cfg_t c;
    int       g;
    c.raw = ($urandom_range(0, 3) == 0);
    g = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65536) - 32768
                                    : $urandom_range(8192, 24576);
    c.gx = GAIN_W'(g);
    g = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65536) - 32768
                                    : $urandom_range(8192, 24576);
    c.gy = GAIN_W'(g);
    c.ox = ($urandom_range(0, 1) == 0) ? OFS_W'($urandom) : OFS_W'($urandom_range(0, 600) - 300);
    c.oy = ($urandom_range(0, 1) == 0) ? OFS_W'($urandom) : OFS_W'($urandom_range(0, 600) - 300);
    c.lim = ($urandom_range(0, 2) == 0) ? LIMIT_W'($urandom_range(1, 8191))
                                        : LIMIT_W'($urandom_range(8, 200));
    return c;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic sample_t words6(logic [RAW_W-1:0] w0, logic [RAW_W-1:0] w1,
                                     logic [RAW_W-1:0] w2, logic [RAW_W-1:0] w3,
                                     logic [RAW_W-1:0] w4, logic [RAW_W-1:0] w5);
    sample_t s;
    s.cmd   = CMD_BURST;
    s.words = {w5, w4, w3, w2, w1, w0};
    return s;
  endfunction

  function automatic sample_t pen_up_item();
    sample_t s;
    s.cmd   = CMD_PEN_UP;
    s.words = {MAX_WORDS{RAW_W'($urandom)}};
    return s;
  endfunction

  // six words jittered around a panel position, with an occasional outlier
  function automatic sample_t make_burst(int base);
    sample_t s;
    int      v;
    s.cmd = CMD_BURST;
    for (int k = 0; k < MAX_WORDS; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        s.words[k] = RAW_W'($urandom);
      end else begin
        v = base + $urandom_range(0, 8) - 4;
        if (v < 0) v = 0;
        if (v > VAL_MAX) v = VAL_MAX;
        s.words[k] = {VAL_W'(v), VAL_SHIFT'($urandom)};
      end
    end
    return s;
  endfunction

  function automatic int pick_position();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 20);
      1:       return VAL_MAX - $urandom_range(0, 20);
      default: return $urandom_range(0, VAL_MAX);
    endcase
  endfunction

  // second reading of the pair: usually close, sometimes far off
  function automatic int pick_partner(int p);
    int d;
    d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 60);
    p = ($urandom_range(0, 1) == 0) ? p + d : p - d;
    if (p < 0) p = 0;
    if (p > VAL_MAX) p = VAL_MAX;
    return p;
  endfunction

  task automatic run_touch_traffic(input int n_items, input int hold_at, input int drain_at);
    int sent;
    int pick;
    int px, py;
    int nb;
    sent = 0;
    while (sent < n_items) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_req = 1'b1;
        hold_at = -1;
      end
      if (drain_at >= 0 && sent >= drain_at) begin
        release_samples();
        wait_drained();
        drain_at = -1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        // well-formed X, Y, X, Y scan
        px = pick_position();
        py = pick_position();
        send_sample(make_burst(px));
        send_sample(make_burst(py));
        send_sample(make_burst(pick_partner(px)));
        send_sample(make_burst(pick_partner(py)));
        sent += 4;
      end else if (pick < 88) begin
        send_sample(pen_up_item());
        sent += 1;
      end else if (pick < 94) begin
        // scan broken off by a release
        nb = $urandom_range(1, 3);
        repeat (nb) send_sample(make_burst(pick_position()));
        send_sample(pen_up_item());
        sent += nb + 1;
      end else begin
        send_sample(words6(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                           RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom)));
        sent += 1;
      end
    end
  endtask

  function automatic void add_row(sample_t s, bit typed, result_t r);
    directed_row_t row;
    row.s     = s;
    row.typed = typed;
    row.res   = r;
    touch_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    cal_cfg_t c;
    sample_t  zeros, maxes, mid;

    zeros = words6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    maxes = words6(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    mid   = words6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);

    // double release after reset idles the coordinates
    add_row(pen_up_item(), 1'b1, '{1'b0, 1'b0, 1'b0, COORD_IDLE, COORD_IDLE});
    add_row(pen_up_item(), 1'b1, '{1'b0, 1'b0, 1'b0, COORD_IDLE, COORD_IDLE});
    // all-zero scan, zero gain: first press at origin
    add_row(zeros, 1'b0, '0);
    add_row(zeros, 1'b0, '0);
    add_row(zeros, 1'b0, '0);
    add_row(zeros, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000});
    // full-scale scan, still pressed
    add_row(maxes, 1'b0, '0);
    add_row(maxes, 1'b0, '0);
    add_row(maxes, 1'b0, '0);
    add_row(maxes, 1'b1, '{1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000});
    // release keeps coordinates, second release idles them
    add_row(pen_up_item(), 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000});
    add_row(pen_up_item(), 1'b1, '{1'b0, 1'b0, 1'b0, COORD_IDLE, COORD_IDLE});
    // X readings disagree: coordinates held
    add_row(zeros, 1'b0, '0);
    add_row(mid,   1'b0, '0);
    add_row(maxes, 1'b0, '0);
    add_row(mid,   1'b0, '0);
    // release in mid scan drops the partial scan
    add_row(mid,   1'b0, '0);
    add_row(mid,   1'b0, '0);
    add_row(pen_up_item(), 1'b0, '0);
    // min and max words trimmed out of each burst
    add_row(words6(16'h0000, 16'hFFFF, 16'h1230, 16'h1238, 16'h1240, 16'h1248), 1'b0, '0);
    add_row(words6(16'hFFFF, 16'h4007, 16'h0000, 16'h4010, 16'h4018, 16'h3FF8), 1'b0, '0);
    add_row(words6(16'h1250, 16'h1258, 16'h0000, 16'h1260, 16'hFFFF, 16'h1268), 1'b0, '0);
    add_row(words6(16'h4020, 16'h0000, 16'h4028, 16'hFFFF, 16'h4030, 16'h4038), 1'b0, '0);

    // reset
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed table under reset calibration
    foreach (touch_rows[i]) send_sample(touch_rows[i].s, touch_rows[i].typed, touch_rows[i].res);

    // raw readings, widest agreement window
    c = '{1'b1, '0, '0, '0, '0, LIMIT_W'(8191)};
    load_cal(c);
    run_touch_traffic(200, -1, -1);

    // gain and offset extremes, narrowest agreeing window; long result hold-off
    c = '{1'b0, 17'sd32768, -16'sd32768, -17'sd32768, 16'sd32767, LIMIT_W'(1)};
    load_cal(c);
    run_touch_traffic(200, 40, -1);

    // unity gain, zero window: never agrees; sender pauses for a drain
    c = '{1'b0, 17'sd16384, 16'sd0, 17'sd16384, 16'sd0, LIMIT_W'(0)};
    load_cal(c);
    run_touch_traffic(100, -1, 50);

    repeat (5) begin
      load_cal(rand_cal());
      run_touch_traffic(200, -1, -1);
    end

    // closing stretch with no idling on either side
    load_cal(rand_cal());
    idle_on = 1'b0;
    run_touch_traffic(150, -1, -1);

    release_samples();
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("touch_panel_sample_filter_tb: clean");
    end else begin
      $display("touch_panel_sample_filter_tb: errors");
    end
    $finish;
  end

endmodule
